// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the walker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pgw_pkg.sv =====
// ----------------------------------------------------------------------------
// pgw_pkg
// Types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgw_pkg;

  localparam int VA_W   = 48;
  localparam int PA_W   = 52;
  localparam int WI_W   = 16;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_XLATE = 2'd2,
    OP_UNMAP = 2'd3
  } pgw_op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam int PRESENT_BIT = 0;
  localparam int HUGE_BIT    = 7;

  typedef struct packed {
    pgw_op_t             op;
    logic [VA_W-1:0]     va;
    logic [WI_W-1:0]     wi;
    logic [DATA_W-1:0]   wdata;
    logic                wi_out;
  } pgw_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pgw_ram.sv =====
// ----------------------------------------------------------------------------
// pgw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_front.sv =====
// ----------------------------------------------------------------------------
// pgw_front
// Accepts input beats, flags out-of-range word indexes, and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgw_front #(
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output      logic                          in_full,
  input  wire logic [1:0]                    in_op,
  input  wire logic [pgw_pkg::VA_W-1:0]      in_virt_addr,
  input  wire logic [pgw_pkg::WI_W-1:0]      in_word_index,
  input  wire logic [pgw_pkg::DATA_W-1:0]    in_write_data,
  output      logic                          q_valid,
  output      pgw_pkg::pgw_cmd_t             q_cmd,
  input  wire logic                          q_pop
);

  pgw_pkg::pgw_cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok, pop_ok;
  pgw_pkg::pgw_cmd_t new_cmd;

  assign in_full = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_comb begin
    new_cmd.op     = pgw_pkg::pgw_op_t'(in_op);
    new_cmd.va     = in_virt_addr;
    new_cmd.wi     = in_word_index;
    new_cmd.wdata  = in_write_data;
    new_cmd.wi_out = (32'(in_word_index) >= 32'(TABLE_WORDS));
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_ok) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_back.sv =====
// ----------------------------------------------------------------------------
// pgw_back
// Executes queued commands against the table RAM: word access and the walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgw_back #(
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pgw_pkg::PA_W-1:0]      cfg_wdata,
  input  wire logic                          q_valid,
  input  wire pgw_pkg::pgw_cmd_t             q_cmd,
  output      logic                          q_pop,
  output      logic                          out_empty,
  input  wire logic                          out_pop,
  output      logic [pgw_pkg::PA_W-1:0]      out_xlat_addr,
  output      logic [1:0]                    out_status,
  output      logic [pgw_pkg::DATA_W-1:0]    out_read_data
);

  localparam int AW = $clog2(TABLE_WORDS);
  localparam int WW = 49;
  localparam logic [1:0] LVL_DIR  = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WALK
  } state_t;

  state_t                       state_r, state_nxt;
  pgw_pkg::pgw_cmd_t            cmd_r, cmd_nxt;
  logic [1:0]                   level_r, level_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [pgw_pkg::PA_W-1:0]     root_r, root_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pgw_pkg::PA_W-1:0]     out_phys_r, out_phys_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [pgw_pkg::DATA_W-1:0]   out_rdata_r, out_rdata_nxt;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [pgw_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;

  logic [WW-1:0]                root_w, next_w;
  logic                         root_out, next_out;
  logic [8:0]                   va_idx;
  logic [31:0]                  wi_ext;
  logic [pgw_pkg::DATA_W-1:0]   e;

  pgw_ram #(
    .WIDTH (pgw_pkg::DATA_W),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_empty     = !out_valid_r;
  assign out_xlat_addr = out_phys_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_rdata_r;

  assign e        = ram_rdata;
  assign wi_ext   = 32'(q_cmd.wi);
  assign root_w   = {root_r[51:12], q_cmd.va[47:39]};
  assign root_out = (root_w >= WW'(TABLE_WORDS));
  assign next_w   = {e[51:12], va_idx};
  assign next_out = (next_w >= WW'(TABLE_WORDS));

  always_comb begin
    case (level_r)
      2'd0:    va_idx = cmd_r.va[38:30];
      2'd1:    va_idx = cmd_r.va[29:21];
      default: va_idx = cmd_r.va[20:12];
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    level_nxt      = level_r;
    addr_nxt       = addr_r;
    root_nxt       = cfg_we ? cfg_wdata : root_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    out_phys_nxt   = out_phys_r;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = '0;
    ram_raddr      = '0;
    ram_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || out_pop)) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          out_phys_nxt   = '0;
          out_rdata_nxt  = '0;
          unique case (q_cmd.op)
            pgw_pkg::OP_WRITE: begin
              out_valid_nxt = 1'b1;
              if (q_cmd.wi_out) begin
                out_status_nxt = pgw_pkg::ST_OUTSIDE;
              end else begin
                out_status_nxt = pgw_pkg::ST_OK;
                ram_we         = 1'b1;
                ram_waddr      = wi_ext[AW-1:0];
                ram_wdata      = q_cmd.wdata;
              end
            end
            pgw_pkg::OP_READ: begin
              if (q_cmd.wi_out) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pgw_pkg::ST_OUTSIDE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = wi_ext[AW-1:0];
                state_nxt = S_READ;
              end
            end
            pgw_pkg::OP_XLATE, pgw_pkg::OP_UNMAP: begin
              if (root_out) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pgw_pkg::ST_OUTSIDE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = root_w[AW-1:0];
                addr_nxt  = root_w[AW-1:0];
                level_nxt = 2'd0;
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = pgw_pkg::ST_OK;
        out_rdata_nxt  = e;
        state_nxt      = S_IDLE;
      end
      S_WALK: begin
        if (!e[pgw_pkg::PRESENT_BIT]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgw_pkg::ST_ABSENT;
          state_nxt      = S_IDLE;
        end else if (level_r == LVL_LEAF) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgw_pkg::ST_OK;
          out_phys_nxt   = {e[51:12], cmd_r.va[11:0]};
          state_nxt      = S_IDLE;
        end else if (level_r == LVL_DIR && e[pgw_pkg::HUGE_BIT]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgw_pkg::ST_OK;
          state_nxt      = S_IDLE;
          if (cmd_r.op == pgw_pkg::OP_UNMAP) begin
            ram_we    = 1'b1;
            ram_waddr = addr_r;
          end else begin
            out_phys_nxt = {e[51:21], cmd_r.va[20:0]};
          end
        end else if (next_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgw_pkg::ST_OUTSIDE;
          state_nxt      = S_IDLE;
        end else if (level_r == LVL_DIR && cmd_r.op == pgw_pkg::OP_UNMAP) begin
          // leaf is cleared whether or not it is present
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgw_pkg::ST_OK;
          state_nxt      = S_IDLE;
          ram_we         = 1'b1;
          ram_waddr      = next_w[AW-1:0];
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_w[AW-1:0];
          addr_nxt  = next_w[AW-1:0];
          level_nxt = level_r + 2'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    level_r      <= level_nxt;
    addr_r       <= addr_nxt;
    out_phys_r   <= out_phys_nxt;
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker_core.sv =====
// The back end runs one queued command at a time; the front queue holds two more.
// A walk reads one level at a time on the single table RAM read port, since each
// level's address comes from the previous entry.
// Reset: synchronous, active low; clears the command queue, the walker, the result
// register and the root base register. The table memory is not cleared.
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Four-level page table walker over a local table memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_core #(
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pgw_pkg::PA_W-1:0]      cfg_wdata,
  input  wire logic                          in_push,
  output      logic                          in_full,
  input  wire logic [1:0]                    in_op,
  input  wire logic [pgw_pkg::VA_W-1:0]      in_virt_addr,
  input  wire logic [pgw_pkg::WI_W-1:0]      in_word_index,
  input  wire logic [pgw_pkg::DATA_W-1:0]    in_write_data,
  output      logic                          out_empty,
  input  wire logic                          out_pop,
  output      logic [pgw_pkg::PA_W-1:0]      out_xlat_addr,
  output      logic [1:0]                    out_status,
  output      logic [pgw_pkg::DATA_W-1:0]    out_read_data
);

  logic              q_valid;
  logic              q_pop;
  pgw_pkg::pgw_cmd_t q_cmd;

  pgw_front #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_virt_addr  (in_virt_addr),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  pgw_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_xlat_addr (out_xlat_addr),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pgw_checker.sv =====
// ----------------------------------------------------------------------------
// pgw_checker
// Port-level checks on the walker result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pgw_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic [pgw_pkg::PA_W-1:0]      out_xlat_addr,
  input wire logic [1:0]                    out_status,
  input wire logic [pgw_pkg::DATA_W-1:0]    out_read_data
);

  logic status_known;
  logic fail_beat;
  logic stall_beat;
  logic [pgw_pkg::PA_W+pgw_pkg::DATA_W+1:0] out_beat;

  assign status_known = (out_status == pgw_pkg::ST_OK) ||
                        (out_status == pgw_pkg::ST_ABSENT) ||
                        (out_status == pgw_pkg::ST_OUTSIDE);
  assign fail_beat    = !out_empty && (out_status != pgw_pkg::ST_OK);
  assign stall_beat   = !out_empty && !out_pop;
  assign out_beat     = {out_xlat_addr, out_status, out_read_data};

  `ASSERT_CLK(a_status_code, clk, rst_n, !out_empty |-> status_known, "bad status code")
  `ASSERT_CLK(a_fail_no_addr, clk, rst_n, fail_beat |-> (out_xlat_addr == '0), "address on failed beat")
  `ASSERT_CLK(a_fail_no_data, clk, rst_n, fail_beat |-> (out_read_data == '0), "data on failed beat")
  `ASSERT_CLK(a_result_held, clk, rst_n, stall_beat |=> !out_empty, "stalled beat dropped")
  `ASSERT_CLK(a_result_stable, clk, rst_n, stall_beat |=> $stable(out_beat), "stalled beat changed")

endmodule

bind four_level_page_table_walker_core pgw_checker u_pgw_checker (.*);

`default_nettype wire

// ===== bench/tb_four_level_page_table_walker_core.sv =====
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_core
// Self-checking bench for the four-level page table walker. A behavioral copy
// of the walker (table memory, root base, walk) predicts one reply per beat.
// Directed tests cover word access, full walks, huge pages, absent entries,
// out-of-window tables and unmap. Random phases then build and reshape page
// tables under several root settings, with random gaps and stalls on both
// sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_core;

  localparam int TABLE_WORDS = 65536;
  localparam int ITEM_TARGET = 1130;

  localparam logic [pgw_pkg::VA_W-1:0] VA_LEAF    = {9'd1, 9'd2, 9'd3, 9'd4, 12'hABC};
  localparam logic [pgw_pkg::VA_W-1:0] VA_HUGE    = {9'd1, 9'd2, 9'd5, 21'h1FFFFF};
  localparam logic [pgw_pkg::VA_W-1:0] VA_NO_ROOT = {9'd7, 9'd0, 9'd0, 9'd0, 12'h000};
  localparam logic [pgw_pkg::VA_W-1:0] VA_NO_LEAF = {9'd1, 9'd2, 9'd3, 9'd9, 12'h5A5};
  localparam logic [pgw_pkg::VA_W-1:0] VA_FAR     = {9'd1, 9'd2, 9'd6, 9'd0, 12'h000};

  typedef struct packed {
    logic [pgw_pkg::PA_W-1:0]   pa;
    logic [1:0]                 st;
    logic [pgw_pkg::DATA_W-1:0] rd;
  } xlate_reply_t;

  typedef struct packed {
    logic [1:0]       st;
    logic             huge;
    logic             hole;   // stopped at a word never written
    logic [2:0]       depth;  // words located so far
    logic [3:0][15:0] path;   // located words, root level first
  } walk_trace_t;

  logic                         clk;
  logic                         rst_n         = 1'b0;
  logic                         cfg_we        = 1'b0;
  logic [pgw_pkg::PA_W-1:0]     cfg_wdata     = '0;
  logic                         in_push       = 1'b0;
  logic                         in_full;
  logic [1:0]                   in_op         = '0;
  logic [pgw_pkg::VA_W-1:0]     in_virt_addr  = '0;
  logic [pgw_pkg::WI_W-1:0]     in_word_index = '0;
  logic [pgw_pkg::DATA_W-1:0]   in_write_data = '0;
  logic                         out_empty;
  logic                         out_pop       = 1'b0;
  logic [pgw_pkg::PA_W-1:0]     out_xlat_addr;
  logic [1:0]                   out_status;
  logic [pgw_pkg::DATA_W-1:0]   out_read_data;

  logic [pgw_pkg::DATA_W-1:0]   table_words [TABLE_WORDS];
  bit                           word_written [TABLE_WORDS];
  logic [pgw_pkg::WI_W-1:0]     written_list [$];
  logic [pgw_pkg::PA_W-1:0]     root_base = '0;
  logic [pgw_pkg::VA_W-1:0]     va_pool [$];
  xlate_reply_t                 replies_due [$];

  bit steady = 1'b0;
  int items_sent, xlate_count, unmap_count, roots_set;
  int replies_checked, mismatches;
  int walk_ok, walk_absent, walk_outside;

  four_level_page_table_walker_core #(
    .TABLE_WORDS (TABLE_WORDS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_virt_addr  (in_virt_addr),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_xlat_addr (out_xlat_addr),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [pgw_pkg::VA_W-1:0] rand_va();
    return pgw_pkg::VA_W'({$urandom, $urandom});
  endfunction

  function automatic void store_word(logic [pgw_pkg::WI_W-1:0] wi,
                                     logic [pgw_pkg::DATA_W-1:0] wd);
    if (!word_written[wi]) begin
      word_written[wi] = 1'b1;
      written_list.push_back(wi);
    end
    table_words[wi] = wd;
  endfunction

  function automatic walk_trace_t trace_walk(logic [pgw_pkg::VA_W-1:0] va);
    walk_trace_t t;
    logic [pgw_pkg::PA_W-1:0] tbl;
    logic [63:0] w;
    logic [pgw_pkg::DATA_W-1:0] e;
    t = '0;
    t.st = pgw_pkg::ST_OK;
    tbl = root_base;
    for (int lvl = 0; lvl < 4; lvl++) begin
      w = {15'b0, tbl[51:12], 9'b0} + 64'((va >> (39 - 9 * lvl)) & 48'h1FF);
      if (w >= TABLE_WORDS) begin
        t.st = pgw_pkg::ST_OUTSIDE;
        return t;
      end
      t.path[lvl] = w[15:0];
      t.depth = 3'(lvl + 1);
      if (!word_written[w[15:0]]) begin
        t.hole = 1'b1;
        return t;
      end
      if (lvl == 3) return t;
      e = table_words[w[15:0]];
      if (!e[pgw_pkg::PRESENT_BIT]) begin
        t.st = pgw_pkg::ST_ABSENT;
        return t;
      end
      if (lvl == 2 && e[pgw_pkg::HUGE_BIT]) begin
        t.huge = 1'b1;
        return t;
      end
      tbl = {e[51:12], 12'b0};
    end
    return t;
  endfunction

  function automatic xlate_reply_t predict_reply(pgw_pkg::pgw_op_t op,
                                                 logic [pgw_pkg::VA_W-1:0] va,
                                                 logic [pgw_pkg::WI_W-1:0] wi,
                                                 logic [pgw_pkg::DATA_W-1:0] wd);
    xlate_reply_t r;
    walk_trace_t t;
    logic [pgw_pkg::DATA_W-1:0] leaf;
    r = '0;
    r.st = pgw_pkg::ST_OK;
    case (op)
      pgw_pkg::OP_WRITE: store_word(wi, wd);
      pgw_pkg::OP_READ: r.rd = table_words[wi];
      default: begin
        t = trace_walk(va);
        r.st = t.st;
        if (t.st == pgw_pkg::ST_OK) begin
          if (op == pgw_pkg::OP_UNMAP) begin
            store_word(t.huge ? t.path[2] : t.path[3], '0);
          end else if (t.huge) begin
            r.pa = {table_words[t.path[2]][51:21], va[20:0]};
          end else begin
            leaf = table_words[t.path[3]];
            if (!leaf[pgw_pkg::PRESENT_BIT]) r.st = pgw_pkg::ST_ABSENT;
            else r.pa = {leaf[51:12], va[11:0]};
          end
        end
        if (r.st == pgw_pkg::ST_OK) walk_ok++;
        else if (r.st == pgw_pkg::ST_ABSENT) walk_absent++;
        else walk_outside++;
      end
    endcase
    return r;
  endfunction

  // Random table entry for a level: mostly present and pointing into the window.
  function automatic logic [pgw_pkg::DATA_W-1:0] make_entry(int lvl);
    logic [pgw_pkg::DATA_W-1:0] e;
    int r;
    e = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    e[pgw_pkg::PRESENT_BIT] = (r >= 8);
    if (lvl == 2) e[pgw_pkg::HUGE_BIT] = (r >= 70);
    if (lvl < 3 && r >= 8 && !(lvl == 2 && r >= 70)) begin
      if (r < 14) e[51] = 1'b1;
      else e[51:12] = 40'($urandom_range(0, TABLE_WORDS / 512 - 1));
    end
    return e;
  endfunction

  function automatic logic [pgw_pkg::VA_W-1:0] pick_va();
    logic [pgw_pkg::VA_W-1:0] va;
    logic [pgw_pkg::VA_W-1:0] fresh;
    int r;
    fresh = rand_va();
    r = $urandom_range(0, 99);
    if (r < 15 || va_pool.size() == 0) begin
      va_pool.push_back(fresh);
      if (va_pool.size() > 24) va_pool.delete(0);
      return fresh;
    end
    va = va_pool[$urandom_range(0, va_pool.size() - 1)];
    if (r < 50) va[11:0] = fresh[11:0];
    else if (r < 75) va[20:0] = fresh[20:0];
    else if (r < 90) va[29:0] = fresh[29:0];
    return va;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic send_beat(pgw_pkg::pgw_op_t op, logic [pgw_pkg::VA_W-1:0] va,
                           logic [pgw_pkg::WI_W-1:0] wi,
                           logic [pgw_pkg::DATA_W-1:0] wd);
    int gap;
    in_push       <= 1'b1;
    in_op         <= op;
    in_virt_addr  <= va;
    in_word_index <= wi;
    in_write_data <= wd;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    replies_due.push_back(predict_reply(op, va, wi, wd));
    items_sent++;
    if (op == pgw_pkg::OP_XLATE) xlate_count++;
    if (op == pgw_pkg::OP_UNMAP) unmap_count++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_word(logic [pgw_pkg::WI_W-1:0] wi, logic [pgw_pkg::DATA_W-1:0] wd);
    send_beat(pgw_pkg::OP_WRITE, rand_va(), wi, wd);
  endtask

  task automatic get_word(logic [pgw_pkg::WI_W-1:0] wi);
    send_beat(pgw_pkg::OP_READ, rand_va(), wi, {$urandom, $urandom});
  endtask

  // Fills any never-written word on the walk path before the walk beat.
  task automatic walk_op(pgw_pkg::pgw_op_t op, logic [pgw_pkg::VA_W-1:0] va);
    walk_trace_t t;
    t = trace_walk(va);
    while (t.hole) begin
      put_word(t.path[t.depth - 1], make_entry(t.depth - 1));
      t = trace_walk(va);
    end
    send_beat(op, va, pgw_pkg::WI_W'($urandom), {$urandom, $urandom});
  endtask

  task automatic set_root(logic [pgw_pkg::PA_W-1:0] value);
    in_push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    root_base = value;
    roots_set++;
  endtask

  task automatic test_word_access();
    set_root('0);
    put_word(16'h0000, 64'h0);
    put_word(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    get_word(16'h0000);
    get_word(16'hFFFF);
  endtask

  // Root page 0 -> page 1 -> page 2 -> page 3, ignored bits set along the way.
  task automatic test_four_level_walk();
    put_word(16'd1, 64'h0000_0000_0000_1001);
    put_word(16'd514, 64'hFFF0_0000_0000_2FFF);
    put_word(16'd1027, 64'h0000_0000_0000_3001);
    put_word(16'd1540, 64'hFFFF_FFFF_FFFF_FFFF);
    walk_op(pgw_pkg::OP_XLATE, VA_LEAF);
  endtask

  task automatic test_huge_page();
    put_word(16'd1029, 64'hFFFF_FFFF_FFFF_FFFF);
    walk_op(pgw_pkg::OP_XLATE, VA_HUGE);
  endtask

  task automatic test_not_present();
    put_word(16'd7, 64'hFFFF_FFFF_FFFF_FFFE);
    walk_op(pgw_pkg::OP_XLATE, VA_NO_ROOT);
    put_word(16'd1545, 64'hFFFF_FFFF_FFFF_FFFE);
    walk_op(pgw_pkg::OP_XLATE, VA_NO_LEAF);
  endtask

  task automatic test_outside_window();
    put_word(16'd1030, 64'h0000_0000_0008_0001);
    walk_op(pgw_pkg::OP_XLATE, VA_FAR);
    set_root(52'h0_0000_0008_0000);
    walk_op(pgw_pkg::OP_XLATE, VA_LEAF);
    set_root(52'hF_FFFF_FFFF_F000);
    walk_op(pgw_pkg::OP_XLATE, {pgw_pkg::VA_W{1'b1}});
    set_root(52'h0_0000_0000_0FFF);
    walk_op(pgw_pkg::OP_XLATE, VA_LEAF);
    walk_op(pgw_pkg::OP_UNMAP, VA_FAR);
  endtask

  task automatic test_unmap();
    walk_op(pgw_pkg::OP_UNMAP, VA_LEAF);
    walk_op(pgw_pkg::OP_XLATE, VA_LEAF);
    walk_op(pgw_pkg::OP_UNMAP, VA_HUGE);
    walk_op(pgw_pkg::OP_XLATE, VA_HUGE);
    walk_op(pgw_pkg::OP_UNMAP, VA_NO_LEAF);
    walk_op(pgw_pkg::OP_UNMAP, VA_NO_ROOT);
  endtask

  task automatic random_op();
    walk_trace_t t;
    logic [pgw_pkg::VA_W-1:0] va;
    int r;
    int k;
    r = $urandom_range(0, 99);
    va = pick_va();
    if (r < 40) begin
      walk_op(pgw_pkg::OP_XLATE, va);
    end else if (r < 55) begin
      walk_op(pgw_pkg::OP_UNMAP, va);
    end else if (r < 67) begin
      get_word(written_list[$urandom_range(0, written_list.size() - 1)]);
    end else if (r < 92) begin
      // rewrite one entry on an existing path to reshape the tables
      t = trace_walk(va);
      if (t.depth == 0) begin
        walk_op(pgw_pkg::OP_XLATE, va);
      end else begin
        k = $urandom_range(0, t.depth - 1);
        put_word(t.path[k], make_entry(k));
      end
    end else begin
      put_word(pgw_pkg::WI_W'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic test_random_walks();
    logic [pgw_pkg::PA_W-1:0] root;
    int r;
    int quota;
    int start;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) root = {40'($urandom_range(0, TABLE_WORDS / 512 - 1)), 12'($urandom)};
      else if (r < 70) root = 52'h0_0000_0007_FFFF;
      else if (r < 80) root = '0;
      else root = {1'b1, 39'({$urandom, $urandom}), 12'b0};
      quota = (r < 80) ? $urandom_range(80, 140) : 15;
      set_root(root);
      steady = ($urandom_range(0, 3) == 0);
      start = items_sent;
      while (items_sent - start < quota && items_sent < ITEM_TARGET) random_op();
    end
  endtask

  task automatic check_reply();
    xlate_reply_t want;
    if (replies_due.size() == 0) begin
      report_mismatch("unexpected reply status", 64'(out_status), 64'h0);
      return;
    end
    want = replies_due.pop_front();
    if (out_xlat_addr !== want.pa)
      report_mismatch("xlat_addr", 64'(out_xlat_addr), 64'(want.pa));
    if (out_status !== want.st) report_mismatch("status", 64'(out_status), 64'(want.st));
    if (out_read_data !== want.rd) report_mismatch("read_data", out_read_data, want.rd);
    replies_checked++;
  endtask

  // Reply side: check at the falling edge, the beat completes at the next rise.
  initial begin : reply_monitor
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rst_n && out_pop && !out_empty) check_reply();
      @(posedge clk);
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = steady ? 0 : idle_len();
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_word_access();
    test_four_level_walk();
    test_huge_page();
    test_not_present();
    test_outside_window();
    test_unmap();
    test_random_walks();
    in_push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d beats (%0d translations, %0d unmaps) under %0d root settings.",
             items_sent, xlate_count, unmap_count, roots_set);
    $display("Walk outcomes: %0d ok, %0d not present, %0d outside; %0d replies checked.",
             walk_ok, walk_absent, walk_outside, replies_checked);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d replies outstanding", replies_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
